/* sv/fbha_pkg.sv */
`timescale 1ns / 1ps
package fbha_pkg;

    // work width for sizes: holds size plus header and the doubled block sizes
    localparam int XW = 19;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;
    localparam logic [1:0] POL_BUDDY = 2'd3;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_BASE   = 2'd1;
    localparam logic [1:0] CFG_MEMB   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        K_ALLOC_FIT,
        K_ALLOC_BUD,
        K_FREE_FIT,
        K_FREE_BUD
    } t_kind;

    typedef enum logic [3:0] {
        S_INIT,
        S_INITB,
        S_INITW,
        S_IDLE,
        S_BSIZE,
        S_SCAN0,
        S_SCAN,
        S_DECIDE,
        S_PCNT,
        S_WR,
        S_RMV,
        S_INS,
        S_SPLIT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]  policy;
        logic [31:0] base_address;
        logic [16:0] memory_bytes;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] user_address;
        logic [16:0] header_word;
    } t_result;

endpackage

/* sv/fbha_seg_mem.sv */
`timescale 1ns / 1ps
module fbha_seg_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 33
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wa,
    input  logic [DW-1:0] i_wd,
    input  logic [AW-1:0] i_ra,
    output logic [DW-1:0] o_rd
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd <= r_mem[i_ra];
    end
endmodule

/* sv/fbha_ctrl.sv */
`timescale 1ns / 1ps
module fbha_ctrl #(
    parameter int MAX_SEGMENTS = 64,
    parameter int MEM_BYTES    = 65536,
    parameter int MIN_BLOCK    = 16,
    parameter int HEADER_BYTES = 4,
    parameter int IW           = 6,
    parameter int DW           = 33
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fbha_pkg::t_cfg    i_cfg,
    input  logic              i_reinit,
    input  logic              i_valid,
    input  logic              i_req_type,
    input  logic [16:0]       i_request_size,
    input  logic [31:0]       i_block_address,
    input  logic              i_out_free,
    output logic              o_idle,
    output logic              o_done,
    output fbha_pkg::t_result o_res,
    output logic              o_we,
    output logic [IW-1:0]     o_wa,
    output logic [DW-1:0]     o_wd,
    output logic [IW-1:0]     o_ra,
    input  logic [DW-1:0]     i_rd
);
    import fbha_pkg::*;

    localparam int SW = $clog2(MEM_BYTES);
    localparam int LW = SW + 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int PW = 5;

    t_state  r_state, n_state, r_after, n_after;
    t_kind   r_kind, n_kind;
    t_result r_res, n_res;
    logic [CW-1:0] r_cnt, n_cnt, r_idx, n_idx, r_rk, n_rk, r_k, n_k;
    logic [CW-1:0] r_i, n_i, r_rmi, n_rmi, r_pos, n_pos, r_j, n_j;
    logic          r_rv, n_rv, r_rmp, n_rmp;
    logic [LW-1:0] r_region, n_region, r_len, n_len, r_wl, n_wl;
    logic [LW-1:0] r_pl, n_pl, r_lln, n_lln, r_rl, n_rl;
    logic [SW-1:0] r_off, n_off, r_ws, n_ws, r_ps, n_ps, r_lst, n_lst, r_rs, n_rs;
    logic [XW-1:0] r_need, n_need, r_t, n_t;
    logic [16:0]   r_size, n_size;
    logic [1:0]    r_mode, n_mode;
    logic          r_first, n_first, r_pf, n_pf, r_ov, n_ov, r_hr, n_hr, r_ef, n_ef;
    logic [IW-1:0] r_pj, n_pj, r_ej, n_ej;
    logic [PW-1:0] r_pc, n_pc;

    logic [SW-1:0] w_es;
    logic [LW-1:0] w_el;
    logic [16:0]   w_m;
    logic [XW-1:0] w_mx, w_bud, w_hold;
    logic [CW-1:0] w_rk_m1, w_rk_p1, w_k_m1, w_pos_m1;
    logic [31:0]   w_off32;
    logic [XW-1:0] w_lfit;
    logic          w_left, w_right, w_pow2;

    assign w_es     = i_rd[DW-1:LW];
    assign w_el     = i_rd[LW-1:0];
    assign w_m      = (i_cfg.memory_bytes > 17'(MEM_BYTES)) ? 17'(MEM_BYTES)
                                                            : i_cfg.memory_bytes;
    assign w_mx     = XW'(w_m);
    assign w_bud    = ((XW'(r_off) & XW'(r_len)) != '0) ? XW'(r_off) - XW'(r_len)
                                                        : XW'(r_off) + XW'(r_len);
    assign w_hold   = XW'(r_size) + XW'(HEADER_BYTES);
    assign w_rk_m1  = r_rk - CW'(1);
    assign w_rk_p1  = r_rk + CW'(1);
    assign w_k_m1   = r_k - CW'(1);
    assign w_pos_m1 = r_pos - CW'(1);
    assign w_off32  = i_block_address - 32'(HEADER_BYTES) - i_cfg.base_address;
    assign w_lfit   = XW'(i_request_size) + XW'(HEADER_BYTES);
    assign w_pow2   = (i_request_size != '0)
                   && ((i_request_size & (i_request_size - 17'd1)) == '0)
                   && (XW'(i_request_size) >= XW'(MIN_BLOCK));
    assign w_left   = (r_pos != '0) && (XW'(r_lst) + XW'(r_lln) == XW'(r_off));
    assign w_right  = r_hr && (XW'(r_off) + XW'(r_len) == XW'(r_rs));

    assign o_idle = (r_state == S_IDLE);
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_after <= S_IDLE;
            r_cnt   <= '0;
            r_rv    <= 1'b0;
            r_rmp   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_cnt   <= n_cnt;
            r_rv    <= n_rv;
            r_rmp   <= n_rmp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;     r_res <= n_res;       r_idx <= n_idx;
        r_rk <= n_rk;         r_k <= n_k;           r_i <= n_i;
        r_rmi <= n_rmi;       r_pos <= n_pos;       r_j <= n_j;
        r_region <= n_region; r_len <= n_len;       r_wl <= n_wl;
        r_pl <= n_pl;         r_lln <= n_lln;       r_rl <= n_rl;
        r_off <= n_off;       r_ws <= n_ws;         r_ps <= n_ps;
        r_lst <= n_lst;       r_rs <= n_rs;         r_need <= n_need;
        r_t <= n_t;           r_size <= n_size;     r_mode <= n_mode;
        r_first <= n_first;   r_pf <= n_pf;         r_ov <= n_ov;
        r_hr <= n_hr;         r_ef <= n_ef;         r_pj <= n_pj;
        r_ej <= n_ej;         r_pc <= n_pc;
    end

    always_comb begin
        n_state = r_state;  n_after = r_after;  n_kind = r_kind;  n_res = r_res;
        n_cnt = r_cnt;      n_idx = r_idx;      n_rk = r_rk;      n_k = r_k;
        n_i = r_i;          n_rmi = r_rmi;      n_pos = r_pos;    n_j = r_j;
        n_rv = r_rv;        n_rmp = r_rmp;      n_region = r_region;
        n_len = r_len;      n_wl = r_wl;        n_pl = r_pl;      n_lln = r_lln;
        n_rl = r_rl;        n_off = r_off;      n_ws = r_ws;      n_ps = r_ps;
        n_lst = r_lst;      n_rs = r_rs;        n_need = r_need;  n_t = r_t;
        n_size = r_size;    n_mode = r_mode;    n_first = r_first;
        n_pf = r_pf;        n_ov = r_ov;        n_hr = r_hr;      n_ef = r_ef;
        n_pj = r_pj;        n_ej = r_ej;        n_pc = r_pc;
        o_we = 1'b0;
        o_wa = '0;
        o_wd = '0;
        o_ra = '0;
        o_done = 1'b0;

        case (r_state)
            S_INIT: begin
                if (i_cfg.policy != POL_BUDDY) begin
                    n_region = LW'(w_m);
                    n_state  = S_INITW;
                end else if (w_mx < XW'(MIN_BLOCK)) begin
                    n_region = '0;
                    n_state  = S_INITW;
                end else begin
                    n_t     = XW'(MIN_BLOCK);
                    n_state = S_INITB;
                end
            end
            S_INITB: begin
                if ((r_t << 1) <= w_mx) begin
                    n_t = r_t << 1;
                end else begin
                    n_region = LW'(r_t);
                    n_state  = S_INITW;
                end
            end
            S_INITW: begin
                o_we    = (r_region != '0);
                o_wd    = {SW'(0), r_region};
                n_cnt   = (r_region != '0) ? CW'(1) : '0;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_reinit) begin
                    n_state = S_INIT;
                end else if (i_valid) begin
                    n_size  = i_request_size;
                    n_res   = '{status: ST_OK, user_address: '0, header_word: '0};
                    n_after = S_RESP;
                    n_rmp   = 1'b0;
                    n_first = 1'b1;
                    if (!i_req_type && i_cfg.policy != POL_BUDDY) begin
                        n_kind  = K_ALLOC_FIT;
                        n_need  = w_lfit;
                        n_mode  = i_cfg.policy;
                        n_state = S_SCAN0;
                    end else if (!i_req_type) begin
                        n_kind  = K_ALLOC_BUD;
                        n_need  = XW'(MIN_BLOCK);
                        n_mode  = POL_BEST;
                        n_state = S_BSIZE;
                    end else if (i_cfg.policy != POL_BUDDY) begin
                        n_kind = K_FREE_FIT;
                        n_off  = SW'(w_off32);
                        n_len  = LW'(w_lfit);
                        n_need = '1;
                        n_mode = POL_FIRST;
                        if ({1'b0, w_off32} + 33'(w_lfit) > 33'(r_region)) begin
                            n_res.status = ST_NOFIT;
                            n_state      = S_RESP;
                        end else begin
                            n_state = S_SCAN0;
                        end
                    end else begin
                        n_kind = K_FREE_BUD;
                        n_off  = SW'(w_off32);
                        n_len  = LW'(i_request_size);
                        n_need = '1;
                        n_mode = POL_FIRST;
                        if (!w_pow2 || LW'(i_request_size) > r_region
                                || (w_off32 & (32'(i_request_size) - 32'd1)) != '0
                                || {1'b0, w_off32} + 33'(i_request_size)
                                   > 33'(r_region)) begin
                            n_res.status = ST_NOFIT;
                            n_state      = S_RESP;
                        end else begin
                            n_state = S_SCAN0;
                        end
                    end
                end
            end
            S_BSIZE: begin
                if (r_need < w_hold) begin
                    n_need = r_need << 1;
                end else if (r_need > XW'(r_region)) begin
                    n_res.status = ST_NOFIT;
                    n_state      = S_RESP;
                end else begin
                    n_state = S_SCAN0;
                end
            end
            S_SCAN0: begin
                n_pf = 1'b0;  n_ov = 1'b0;  n_hr = 1'b0;  n_ef = 1'b0;
                n_pos = '0;   n_idx = '0;   n_rv = 1'b0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_idx < r_cnt) begin
                    o_ra  = r_idx[IW-1:0];
                    n_rv  = 1'b1;
                    n_rk  = r_idx;
                    n_idx = r_idx + CW'(1);
                end else begin
                    n_rv = 1'b0;
                    if (!r_rv) begin
                        n_state = S_DECIDE;
                    end
                end
                if (r_rv) begin
                    if (XW'(w_el) >= r_need && (!r_pf
                            || (r_mode == POL_BEST && w_el < r_pl)
                            || (r_mode == POL_WORST && w_el > r_pl))) begin
                        n_pf = 1'b1;
                        n_pj = r_rk[IW-1:0];
                        n_pl = w_el;
                        n_ps = w_es;
                    end
                    if (XW'(w_es) < XW'(r_off) + XW'(r_len)
                            && XW'(r_off) < XW'(w_es) + XW'(w_el)) begin
                        n_ov = 1'b1;
                    end
                    if (w_es <= r_off) begin
                        n_pos = w_rk_p1;
                        n_lst = w_es;
                        n_lln = w_el;
                    end else if (!r_hr) begin
                        n_hr = 1'b1;
                        n_rs = w_es;
                        n_rl = w_el;
                    end
                    if (!r_ef && XW'(w_es) == w_bud && w_el == r_len) begin
                        n_ef = 1'b1;
                        n_ej = r_rk[IW-1:0];
                    end
                end
            end
            S_DECIDE: begin
                n_rv = 1'b0;
                case (r_kind)
                    K_ALLOC_FIT: begin
                        if (!r_pf) begin
                            n_res.status = ST_NOFIT;
                            n_state      = S_RESP;
                        end else begin
                            n_res.user_address = i_cfg.base_address + 32'(r_ps)
                                               + 32'(HEADER_BYTES);
                            n_res.header_word  = r_size;
                            if (XW'(r_pl) == r_need) begin
                                n_i     = CW'(r_pj);
                                n_k     = CW'(r_pj) + CW'(1);
                                n_state = S_RMV;
                            end else begin
                                n_i     = CW'(r_pj);
                                n_ws    = r_ps + SW'(r_need);
                                n_wl    = r_pl - LW'(r_need);
                                n_state = S_WR;
                            end
                        end
                    end
                    K_ALLOC_BUD: begin
                        if (!r_pf) begin
                            n_res.status = ST_NOFIT;
                            n_state      = S_RESP;
                        end else begin
                            n_t     = r_need;
                            n_pc    = '0;
                            n_state = S_PCNT;
                        end
                    end
                    K_FREE_FIT: begin
                        if (r_ov) begin
                            n_res.status = ST_NOFIT;
                            n_state      = S_RESP;
                        end else if (w_left && w_right) begin
                            n_i     = w_pos_m1;
                            n_ws    = r_lst;
                            n_wl    = r_lln + r_len + r_rl;
                            n_rmp   = 1'b1;
                            n_rmi   = r_pos;
                            n_state = S_WR;
                        end else if (w_left) begin
                            n_i     = w_pos_m1;
                            n_ws    = r_lst;
                            n_wl    = r_lln + r_len;
                            n_state = S_WR;
                        end else if (w_right) begin
                            n_i     = r_pos;
                            n_ws    = r_off;
                            n_wl    = r_len + r_rl;
                            n_state = S_WR;
                        end else if (r_cnt >= CW'(MAX_SEGMENTS)) begin
                            n_res.status = ST_FULL;
                            n_state      = S_RESP;
                        end else begin
                            n_i     = r_pos;
                            n_k     = r_cnt;
                            n_ws    = r_off;
                            n_wl    = r_len;
                            n_state = S_INS;
                        end
                    end
                    default: begin
                        if (r_first && r_ov) begin
                            n_res.status = ST_NOFIT;
                            n_state      = S_RESP;
                        end else if (r_len < r_region && r_ef) begin
                            // buddy is free: pull it out and retry one order up
                            n_i     = CW'(r_ej);
                            n_k     = CW'(r_ej) + CW'(1);
                            n_after = S_SCAN0;
                            n_off   = (w_bud < XW'(r_off)) ? SW'(w_bud) : r_off;
                            n_len   = r_len << 1;
                            n_first = 1'b0;
                            n_state = S_RMV;
                        end else if (r_first && r_cnt >= CW'(MAX_SEGMENTS)) begin
                            n_res.status = ST_FULL;
                            n_state      = S_RESP;
                        end else begin
                            n_i     = r_pos;
                            n_k     = r_cnt;
                            n_ws    = r_off;
                            n_wl    = r_len;
                            n_after = S_RESP;
                            n_state = S_INS;
                        end
                    end
                endcase
            end
            S_PCNT: begin
                if (r_t < XW'(r_pl)) begin
                    n_pc = r_pc + PW'(1);
                    n_t  = r_t << 1;
                end else if ((CW + PW)'(r_cnt) + (CW + PW)'(r_pc)
                             > (CW + PW)'(MAX_SEGMENTS) + (CW + PW)'(1)) begin
                    n_res.status = ST_FULL;
                    n_state      = S_RESP;
                end else begin
                    n_res.user_address = i_cfg.base_address + 32'(r_ps)
                                       + 32'(HEADER_BYTES);
                    n_res.header_word  = 17'(r_need);
                    n_i = CW'(r_pj);
                    if (r_pc == '0) begin
                        n_k     = CW'(r_pj) + CW'(1);
                        n_state = S_RMV;
                    end else begin
                        // lowest upper half replaces the split block in place
                        n_ws    = r_ps + SW'(r_need);
                        n_wl    = LW'(r_need);
                        n_j     = CW'(r_pj) + CW'(1);
                        n_t     = r_need << 1;
                        n_after = S_SPLIT;
                        n_state = S_WR;
                    end
                end
            end
            S_SPLIT: begin
                if (r_t < XW'(r_pl)) begin
                    n_i     = r_j;
                    n_k     = r_cnt;
                    n_ws    = r_ps + SW'(r_t);
                    n_wl    = LW'(r_t);
                    n_j     = r_j + CW'(1);
                    n_t     = r_t << 1;
                    n_rv    = 1'b0;
                    n_state = S_INS;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_WR: begin
                o_we = 1'b1;
                o_wa = r_i[IW-1:0];
                o_wd = {r_ws, r_wl};
                n_rv = 1'b0;
                if (r_rmp) begin
                    n_rmp   = 1'b0;
                    n_i     = r_rmi;
                    n_k     = r_rmi + CW'(1);
                    n_state = S_RMV;
                end else begin
                    n_state = r_after;
                end
            end
            S_RMV: begin
                if (r_k < r_cnt) begin
                    o_ra = r_k[IW-1:0];
                    n_rv = 1'b1;
                    n_rk = r_k;
                    n_k  = r_k + CW'(1);
                end else begin
                    n_rv = 1'b0;
                    if (!r_rv) begin
                        n_cnt   = r_cnt - CW'(1);
                        n_state = r_after;
                    end
                end
                if (r_rv) begin
                    o_we = 1'b1;
                    o_wa = w_rk_m1[IW-1:0];
                    o_wd = i_rd;
                end
            end
            S_INS: begin
                if (r_k > r_i) begin
                    o_ra = w_k_m1[IW-1:0];
                    n_rv = 1'b1;
                    n_rk = w_k_m1;
                    n_k  = w_k_m1;
                end else begin
                    n_rv = 1'b0;
                end
                if (r_rv) begin
                    o_we = 1'b1;
                    o_wa = w_rk_p1[IW-1:0];
                    o_wd = i_rd;
                end else if (r_k <= r_i) begin
                    o_we    = 1'b1;
                    o_wa    = r_i[IW-1:0];
                    o_wd    = {r_ws, r_wl};
                    n_cnt   = r_cnt + CW'(1);
                    n_state = r_after;
                end
            end
            S_RESP: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end
endmodule

/* sv/fit_and_buddy_heap_allocator.sv */
`timescale 1ns / 1ps
// channel   direction  handshake             word
// request   in         i_valid / o_stall     i_req_type, i_request_size, i_block_address
// result    out        o_valid / i_stall     o_status, o_user_address, o_header_word
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request at a time. A request costs a table scan, then a shift of the table's tail;
// buddy allocate adds a step per size doubling and per split piece plus one shift per extra
// piece, buddy free one scan and shift per merge round. The segment RAM has one read and one
// write port. Reset and writes to policy or memory_bytes rebuild the table.
// A pending config word stalls requests; a stalled result holds the next one.
module fit_and_buddy_heap_allocator #(
    parameter int MAX_SEGMENTS = 64,
    parameter int MEM_BYTES    = 65536,
    parameter int MIN_BLOCK    = 16,
    parameter int HEADER_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [16:0] i_request_size,
    input  logic [31:0] i_block_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_user_address,
    output logic [16:0] o_header_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import fbha_pkg::*;

    localparam int SW = $clog2(MEM_BYTES);
    localparam int DW = 2 * SW + 1;
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    t_cfg    r_cfg;
    t_result w_res;
    logic    w_idle, w_done, w_cfg_we, w_reinit, w_out_free, w_req;
    logic    r_ov;
    logic [1:0]  r_status;
    logic [31:0] r_uaddr;
    logic [16:0] r_hdr;
    logic          w_we;
    logic [IW-1:0] w_wa, w_ra;
    logic [DW-1:0] w_wd, w_rd;

    assign o_cfg_ready = w_idle;
    assign o_stall     = !w_idle || i_cfg_valid;
    assign w_req       = i_valid && !i_cfg_valid;
    assign w_cfg_we    = i_cfg_valid && w_idle;
    assign w_reinit    = w_cfg_we && (i_cfg_index == CFG_POLICY || i_cfg_index == CFG_MEMB);
    assign w_out_free  = !r_ov || !i_stall;

    assign o_valid        = r_ov;
    assign o_status       = r_status;
    assign o_user_address = r_uaddr;
    assign o_header_word  = r_hdr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{policy: POL_FIRST, base_address: '0, memory_bytes: 17'h10000};
            r_ov  <= 1'b0;
        end else begin
            if (w_cfg_we) begin
                case (i_cfg_index)
                    CFG_POLICY: r_cfg.policy       <= i_cfg_data[1:0];
                    CFG_BASE:   r_cfg.base_address <= i_cfg_data;
                    CFG_MEMB:   r_cfg.memory_bytes <= i_cfg_data[16:0];
                    default:    r_cfg              <= r_cfg;
                endcase
            end
            if (w_done) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_status <= w_res.status;
            r_uaddr  <= w_res.user_address;
            r_hdr    <= w_res.header_word;
        end
    end

    fbha_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MEM_BYTES    (MEM_BYTES),
        .MIN_BLOCK    (MIN_BLOCK),
        .HEADER_BYTES (HEADER_BYTES),
        .IW           (IW),
        .DW           (DW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_reinit        (w_reinit),
        .i_valid         (w_req),
        .i_req_type      (i_req_type),
        .i_request_size  (i_request_size),
        .i_block_address (i_block_address),
        .i_out_free      (w_out_free),
        .o_idle          (w_idle),
        .o_done          (w_done),
        .o_res           (w_res),
        .o_we            (w_we),
        .o_wa            (w_wa),
        .o_wd            (w_wd),
        .o_ra            (w_ra),
        .i_rd            (w_rd)
    );

    fbha_seg_mem #(
        .DEPTH (MAX_SEGMENTS),
        .AW    (IW),
        .DW    (DW)
    ) u_mem (
        .i_clk (i_clk),
        .i_we  (w_we),
        .i_wa  (w_wa),
        .i_wd  (w_wd),
        .i_ra  (w_ra),
        .o_rd  (w_rd)
    );
endmodule

/* tb/tb_fit_and_buddy_heap_allocator.sv */
`timescale 1ns / 1ps
module tb_fit_and_buddy_heap_allocator;
    import fbha_pkg::*;

    localparam int SEGS   = 64;
    localparam int MEMMAX = 65536;
    localparam int MINBLK = 16;
    localparam int HDR    = 4;
    localparam int CYCLE_LIMIT = 20000000;

    localparam bit REQ_ALLOC = 1'b0;
    localparam bit REQ_FREE  = 1'b1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_req_type = 1'b0;
    logic [16:0] i_request_size = '0;
    logic [31:0] i_block_address = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_user_address;
    logic [16:0] o_header_word;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    fit_and_buddy_heap_allocator u_dut (.*);

    always #1 i_clk = ~i_clk;

    // model of the heap
    logic [1:0]  cur_policy;
    logic [31:0] cur_base;
    logic [16:0] cur_mem;
    int unsigned seg_off[SEGS];
    int unsigned seg_len[SEGS];
    int unsigned seg_cnt;

    // blocks handed out and still held: offset and header word
    int unsigned held_off[$];
    int unsigned held_hdr[$];

    t_result result_q[$];
    int errors = 0;
    int cycles = 0;
    int hold_left = 0;
    int stall_left = 0;
    bit quiet = 1'b0;

    function automatic int unsigned heap_bytes();
        int unsigned m, b;
        m = (cur_mem > MEMMAX) ? MEMMAX : cur_mem;
        if (cur_policy != POL_BUDDY) return m;
        b = MINBLK;
        if (m < b) return 0;
        while (b * 2 <= m) b = b * 2;
        return b;
    endfunction

    function automatic void rebuild_heap();
        int unsigned r;
        r = heap_bytes();
        for (int i = 0; i < SEGS; i++) begin
            seg_off[i] = 0;
            seg_len[i] = 0;
        end
        seg_len[0] = r;
        seg_cnt = (r != 0) ? 1 : 0;
        held_off.delete();
        held_hdr.delete();
    endfunction

    function automatic void seg_remove(int unsigned idx);
        for (int unsigned i = idx; i + 1 < seg_cnt; i++) begin
            seg_off[i] = seg_off[i+1];
            seg_len[i] = seg_len[i+1];
        end
        seg_cnt--;
    endfunction

    function automatic void seg_insert(int unsigned idx, int unsigned s, int unsigned l);
        if (seg_cnt >= SEGS) return;
        for (int unsigned i = seg_cnt; i > idx; i--) begin
            seg_off[i] = seg_off[i-1];
            seg_len[i] = seg_len[i-1];
        end
        seg_off[idx] = s;
        seg_len[idx] = l;
        seg_cnt++;
    endfunction

    function automatic int seg_pick(longint unsigned need, logic [1:0] mode);
        int found;
        found = -1;
        for (int i = 0; i < seg_cnt; i++) begin
            if (seg_len[i] < need) continue;
            if (found < 0) begin
                found = i;
                if (mode == POL_FIRST) break;
            end else if (mode == POL_BEST && seg_len[i] < seg_len[found]) begin
                found = i;
            end else if (mode == POL_WORST && seg_len[i] > seg_len[found]) begin
                found = i;
            end
        end
        return found;
    endfunction

    function automatic bit seg_overlap(longint unsigned s, longint unsigned l);
        for (int i = 0; i < seg_cnt; i++)
            if (seg_off[i] < s + l && s < longint'(seg_off[i]) + seg_len[i]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic int unsigned seg_slot(int unsigned s);
        int unsigned i;
        i = 0;
        while (i < seg_cnt && seg_off[i] <= s) i++;
        return i;
    endfunction

    function automatic t_result heap_alloc(int unsigned sz);
        t_result r;
        longint unsigned need, bs, t;
        int j;
        int unsigned s, l, pieces;
        r = '0;
        need = sz + HDR;
        if (cur_policy != POL_BUDDY) begin
            j = seg_pick(need, cur_policy);
            if (j < 0) begin
                r.status = ST_NOFIT;
                return r;
            end
            s = seg_off[j];
            if (seg_len[j] == need) begin
                seg_remove(j);
            end else begin
                seg_off[j] += need;
                seg_len[j] -= need;
            end
            r.header_word = sz;
        end else begin
            bs = MINBLK;
            while (bs < need) bs = bs << 1;
            if (bs > heap_bytes()) begin
                r.status = ST_NOFIT;
                return r;
            end
            j = seg_pick(bs, POL_BEST);
            if (j < 0) begin
                r.status = ST_NOFIT;
                return r;
            end
            s = seg_off[j];
            l = seg_len[j];
            pieces = 0;
            for (t = bs; t < l; t = t << 1) pieces++;
            if (seg_cnt - 1 + pieces > SEGS) begin
                r.status = ST_FULL;
                return r;
            end
            seg_remove(j);
            for (t = bs; t < l; t = t << 1) begin
                seg_insert(j, s + t, t);
                j++;
            end
            r.header_word = bs;
        end
        r.status = ST_OK;
        r.user_address = cur_base + s + HDR;
        held_off.push_back(s);
        held_hdr.push_back(r.header_word);
        return r;
    endfunction

    function automatic logic [1:0] heap_free(int unsigned hw, logic [31:0] blk);
        logic [31:0] off;
        int unsigned r, pos, l, sz, b, bud;
        bit left, right, merged;
        int j;
        off = blk - HDR - cur_base;
        r = heap_bytes();
        if (cur_policy != POL_BUDDY) begin
            l = hw + HDR;
            if (longint'(off) + l > r || seg_overlap(off, l)) return ST_NOFIT;
            pos = seg_slot(off);
            right = pos < seg_cnt && off + l == seg_off[pos];
            left = pos > 0 && seg_off[pos-1] + seg_len[pos-1] == off;
            if (left && right) begin
                seg_len[pos-1] += l + seg_len[pos];
                seg_remove(pos);
            end else if (left) begin
                seg_len[pos-1] += l;
            end else if (right) begin
                seg_off[pos] = off;
                seg_len[pos] += l;
            end else begin
                if (seg_cnt >= SEGS) return ST_FULL;
                seg_insert(pos, off, l);
            end
        end else begin
            sz = hw;
            b = MINBLK;
            merged = 1'b0;
            while (b < sz) b = b * 2;
            if (b != sz || sz > r || off % sz != 0 || longint'(off) + sz > r
                    || seg_overlap(off, sz))
                return ST_NOFIT;
            while (sz < r) begin
                bud = ((off / sz) & 1) ? off - sz : off + sz;
                j = -1;
                for (int i = 0; i < seg_cnt; i++)
                    if (j < 0 && seg_off[i] == bud && seg_len[i] == sz) j = i;
                if (j < 0) break;
                merged = 1'b1;
                seg_remove(j);
                if (bud < off) off = bud;
                sz = sz * 2;
            end
            if (!merged && seg_cnt >= SEGS) return ST_FULL;
            seg_insert(seg_slot(off), off, sz);
        end
        return ST_OK;
    endfunction

    function automatic t_result heap_step(bit rt, logic [16:0] sz, logic [31:0] blk);
        t_result r;
        r = '0;
        if (rt == REQ_ALLOC) r = heap_alloc(sz);
        else r.status = heap_free(sz, blk);
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        if (quiet) return 0;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side
    initial begin
        t_result got, want;
        bit take;
        forever begin
            @(negedge i_clk);
            take = o_valid && !i_stall;
            @(posedge i_clk);
            if (take) begin
                got = '{o_status, o_user_address, o_header_word};
                if (result_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result word %p", got);
                end else begin
                    want = result_q.pop_front();
                    if (got.status != want.status || got.user_address != want.user_address
                            || got.header_word != want.header_word) begin
                        errors++;
                        if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0) stall_left = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_word(bit rt, logic [16:0] sz, logic [31:0] blk, output t_result r);
        int g;
        bit ok;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= rt;
        i_request_size <= sz;
        i_block_address <= blk;
        do begin
            @(negedge i_clk);
            ok = !o_stall;
            @(posedge i_clk);
        end while (!ok);
        r = heap_step(rt, sz, blk);
    endtask

    task automatic send_checked(bit rt, logic [16:0] sz, logic [31:0] blk);
        t_result r;
        send_word(rt, sz, blk, r);
        result_q.push_back(r);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        bit ok;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
        end while (!ok);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_POLICY: begin
                cur_policy = data[1:0];
                rebuild_heap();
            end
            CFG_BASE: cur_base = data;
            CFG_MEMB: begin
                cur_mem = data[16:0];
                rebuild_heap();
            end
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic setup(logic [1:0] pol, logic [31:0] base, logic [16:0] mem);
        drain();
        write_reg(CFG_BASE, base);
        write_reg(CFG_MEMB, {15'd0, mem});
        write_reg(CFG_POLICY, {30'd0, pol});
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_traffic(int n, int sync_at);
        int k, idx;
        int unsigned sz, off;
        for (int i = 0; i < n; i++) begin
            if (i == sync_at) drain();
            k = $urandom_range(0, 99);
            if (k < 8) begin
                // junk free
                send_checked(REQ_FREE, $urandom_range(0, 131071), $urandom);
            end else if (k < 14 && held_off.size() != 0) begin
                // near miss on a held block
                idx = $urandom_range(0, held_off.size() - 1);
                off = held_off[idx] + ($urandom_range(0, 1) ? 16 : 0);
                sz = held_hdr[idx] + $urandom_range(0, 1) * $urandom_range(1, 20);
                send_checked(REQ_FREE, sz, cur_base + off + HDR);
            end else if (k < 52 && held_off.size() != 0) begin
                idx = $urandom_range(0, held_off.size() - 1);
                off = held_off[idx];
                sz = held_hdr[idx];
                held_off.delete(idx);
                held_hdr.delete(idx);
                send_checked(REQ_FREE, sz, cur_base + off + HDR);
            end else begin
                k = $urandom_range(0, 99);
                if (k < 75) sz = $urandom_range(0, 120);
                else if (k < 95) sz = $urandom_range(0, 2000);
                else sz = $urandom_range(0, 65536);
                send_checked(REQ_ALLOC, sz, $urandom);
            end
        end
    endtask

    typedef struct {
        bit          rt;
        int unsigned sz;
        logic [31:0] blk;
        bit          known;
        t_result     res;
    } t_row;

    t_row opening[16] = '{
        '{REQ_ALLOC, 0,       32'd4,          1, '{ST_OK,    32'd4, 17'd0}},
        '{REQ_ALLOC, 65536,   32'd0,          1, '{ST_NOFIT, 32'd0, 17'd0}},
        '{REQ_FREE,  0,       32'd4,          1, '{ST_OK,    32'd0, 17'd0}},
        '{REQ_ALLOC, 65532,   32'd0,          1, '{ST_OK,    32'd4, 17'd65532}},
        '{REQ_ALLOC, 0,       32'd0,          1, '{ST_NOFIT, 32'd0, 17'd0}},
        '{REQ_FREE,  65532,   32'd4,          1, '{ST_OK,    32'd0, 17'd0}},
        '{REQ_FREE,  0,       32'd0,          1, '{ST_NOFIT, 32'd0, 17'd0}},
        '{REQ_FREE,  0,       32'd4,          1, '{ST_NOFIT, 32'd0, 17'd0}},
        '{REQ_ALLOC, 100,     32'd0,          0, '{ST_OK,    32'd0, 17'd0}},
        '{REQ_ALLOC, 200,     32'd0,          0, '{ST_OK,    32'd0, 17'd0}},
        '{REQ_ALLOC, 50,      32'd0,          0, '{ST_OK,    32'd0, 17'd0}},
        '{REQ_FREE,  100,     32'd4,          0, '{ST_OK,    32'd0, 17'd0}},
        '{REQ_FREE,  50,      32'd312,        0, '{ST_OK,    32'd0, 17'd0}},
        '{REQ_FREE,  200,     32'd108,        0, '{ST_OK,    32'd0, 17'd0}},
        '{REQ_ALLOC, 65536,   32'd0,          1, '{ST_NOFIT, 32'd0, 17'd0}},
        '{REQ_FREE,  131071,  32'hFFFFFFFF,   1, '{ST_NOFIT, 32'd0, 17'd0}}
    };

    initial begin
        t_result r;
        cur_policy = POL_FIRST;
        cur_base = '0;
        cur_mem = 17'd65536;
        rebuild_heap();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (20) @(posedge i_clk);

        quiet = 1'b1;
        foreach (opening[i]) begin
            send_word(opening[i].rt, opening[i].sz, opening[i].blk, r);
            result_q.push_back(opening[i].known ? opening[i].res : r);
        end
        quiet = 1'b0;

        setup(POL_BEST, 32'h0000_1000, 17'd4096);
        random_traffic(200, -1);

        setup(POL_WORST, 32'hFFFF_FFF0, 17'd65536);
        random_traffic(200, -1);

        // fragment the heap into alternating holes until the table overflows
        setup(POL_FIRST, 32'h1234_5678, 17'd3000);
        quiet = 1'b1;
        for (int i = 0; i < 140; i++) begin
            send_word(REQ_ALLOC, 17'd12, 32'd0, r);
            result_q.push_back(r);
        end
        quiet = 1'b0;
        held_off.delete();
        held_hdr.delete();
        for (int i = 0; i < 140; i += 2) send_checked(REQ_FREE, 17'd12, cur_base + i * 16 + HDR);
        for (int i = 1; i < 140; i += 2) send_checked(REQ_FREE, 17'd12, cur_base + i * 16 + HDR);
        random_traffic(120, -1);

        // receiver holds off so the block backs up
        setup(POL_BUDDY, 32'h0000_0000, 17'd65536);
        hold_left = 400;
        random_traffic(300, -1);

        setup(POL_BUDDY, 32'h0000_0100, 17'd1000);
        random_traffic(150, 75);

        setup(POL_BUDDY, 32'hABCD_EF00, 17'd16);
        random_traffic(50, -1);

        setup(POL_FIRST, 32'h8000_0000, 17'd16);
        random_traffic(50, -1);

        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
